// ===== design/tgdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid deposit / interpolate: shared package
// Request and result word types, job word passed from front to back,
// configuration register set and code constants.
// ----------------------------------------------------------------------------
package tgdi_pkg;

	// Default grid size per axis.
	localparam int GRID_X_DEF = 32;
	localparam int GRID_Y_DEF = 32;
	localparam int GRID_Z_DEF = 32;

	// Widest cell address any legal grid size needs (1024 cubed).
	localparam int CELL_AW_MAX = 30;

	// Request codes.
	localparam logic [1:0] REQ_CLEAR   = 2'd0;
	localparam logic [1:0] REQ_DEPOSIT = 2'd1;
	localparam logic [1:0] REQ_INTERP  = 2'd2;
	localparam logic [1:0] REQ_READ    = 2'd3;

	// Job codes seen by the back end.
	localparam logic [2:0] JOB_CLEAR   = 3'd0;
	localparam logic [2:0] JOB_DEPOSIT = 3'd1;
	localparam logic [2:0] JOB_INTERP  = 3'd2;
	localparam logic [2:0] JOB_READ    = 3'd3;
	localparam logic [2:0] JOB_NOP     = 3'd4;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z     = 3'd2;
	localparam logic [2:0] REG_INV_CELL     = 3'd3;
	localparam logic [2:0] REG_VOLUME_SCALE = 3'd4;
	localparam logic [2:0] REG_DEPOSIT_TYPE = 3'd5;

	localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
	localparam logic [31:0] W_CENTER  = 32'hC000_0000;  // 0.75 in Q0.32
	localparam logic [16:0] HALF_Q16  = 17'd32768;      // 0.5 in Q.16
	localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;

	typedef logic [CELL_AW_MAX-1:0] off_t;
	typedef logic [31:0] wgt_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        mass;
		logic [7:0]         particle_type;
		logic [14:0]        cell_index;
	} in_word_t;

	typedef struct packed {
		logic [31:0] value;
		logic        saturated;
	} out_word_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [31:0]        inv_cell_size;
		logic [31:0]        volume_scale;
		logic [7:0]         deposit_type;
	} cfg_t;

	typedef struct packed {
		logic [2:0]      op;
		logic [31:0]     mass;
		logic [14:0]     cell_index;
		off_t [2:0]      offx;
		off_t [2:0]      offy;
		off_t [2:0]      offz;
		wgt_t [2:0]      wx;
		wgt_t [2:0]      wy;
		wgt_t [2:0]      wz;
	} job_t;

endpackage

// ===== design/tgdi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid: small register queue
// Holds a few words between two sides that stall independently.
// ----------------------------------------------------------------------------
module tgdi_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW:0] DEPTH_V = (PW+1)'(DEPTH);
	localparam logic [PW-1:0] LAST_V = PW'(DEPTH - 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == DEPTH_V);
	assign empty = (cnt_q == '0);
	assign rdata = store_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == LAST_V) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == LAST_V) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_wr) store_q[wptr_q] <= wdata;
	end

endmodule

// ===== design/tgdi_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid: one axis lane
// Maps a position to the nearest cell and its two neighbors with periodic
// wrap, and computes the three TSC weights for that axis.
// ----------------------------------------------------------------------------
module tgdi_axis
	import tgdi_pkg::*;
#(
	parameter int SIZE   = 32,
	parameter int STRIDE = 1,
	parameter int AW     = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] pos,
	input  logic signed [31:0] origin,
	input  logic [31:0]        inv,
	output logic               done,
	output off_t [2:0]         off,
	output wgt_t [2:0]         wgt
);
	localparam int IW = $clog2(SIZE);
	localparam logic [IW:0] SIZE_V = (IW+1)'(SIZE);
	localparam logic [IW-1:0] SIZE_M1 = IW'(SIZE - 1);
	localparam logic [AW-1:0] STRIDE_V = AW'(STRIDE);
	// Reciprocal of the axis size scaled by 2^34; the quotient it gives is
	// at most one below the true one for any cell magnitude below 2^34.
	localparam logic [32:0] RECIP = 33'((64'd1 << 34) / SIZE);
	localparam logic [33:0] SIZE_W = 34'(SIZE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_RC0  = 3'd3;
	localparam logic [2:0] ST_RC1  = 3'd4;
	localparam logic [2:0] ST_RC2  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]  st_q;
	logic        neg_q, near_neg_q, pside_q, done_q;
	logic [32:0] absd_q;
	logic [64:0] mag_q;
	logic [33:0] nsh_q;
	logic [15:0] a_q;
	logic [49:0] plo_q;
	logic [31:0] quo_q;
	logic [IW:0] rest_q;
	off_t [2:0]  off_q;
	wgt_t [2:0]  wgt_q;

	logic signed [32:0] diff;
	logic [32:0] absd;
	logic [63:0] prod;
	logic [48:0] gmag;
	logic signed [49:0] g, t;
	logic signed [33:0] near;
	logic [33:0] nabs;
	logic [15:0] a_n;
	logic [49:0] plo, phi;
	logic [67:0] qsum;
	logic [33:0] qmul, rest;
	logic [IW-1:0] rem, r, rp, rm, i1, i2;
	logic [16:0] sp, sm;
	logic [33:0] sq_p, sq_m;
	logic [31:0] aa;

	assign done = done_q;
	assign off  = off_q;
	assign wgt  = wgt_q;

	// Offset from the origin, as sign and magnitude.
	always_comb begin
		diff = 33'(pos) - 33'(origin);
		absd = diff[32] ? 33'(-diff) : 33'(diff);
	end

	// Magnitude times the inverse cell size; the top bit only occurs alone.
	assign prod = absd_q[31:0] * inv;

	// Grid coordinate, nearest cell, and distance from its center.
	always_comb begin
		gmag = neg_q ? 49'((mag_q + 65'h0FFFF) >> 16) : mag_q[64:16];
		g    = neg_q ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
		t    = g + 50'sd32768;
		near = t[49:16];
		nabs = near[33] ? 34'(-near) : 34'(near);
		a_n  = t[15] ? {1'b0, t[14:0]} : 16'(HALF_Q16 - {2'b0, t[14:0]});
	end

	// Remainder by the axis size through the reciprocal, in two halves,
	// then one compare and subtract; plus the weight squares.
	always_comb begin
		plo  = nsh_q[16:0] * RECIP;
		phi  = nsh_q[33:17] * RECIP;
		qsum = {1'b0, phi, 17'd0} + {18'd0, plo_q};
		qmul = 34'(quo_q) * SIZE_W;
		rest = nsh_q - qmul;
		rem  = (rest_q >= SIZE_V) ? IW'(rest_q - SIZE_V) : IW'(rest_q);
		sp   = HALF_Q16 + {1'b0, a_q};
		sm   = HALF_Q16 - {1'b0, a_q};
		sq_p = sp * sp;
		sq_m = sm * sm;
		aa   = a_q * a_q;
	end

	// Wrap fix-up for negative cells and the two neighbors.
	always_comb begin
		r  = (near_neg_q && rem != '0) ? IW'(SIZE_V - {1'b0, rem}) : rem;
		rp = (r == SIZE_M1) ? '0 : r + 1'b1;
		rm = (r == '0) ? SIZE_M1 : r - 1'b1;
		i1 = pside_q ? rp : rm;
		i2 = pside_q ? rm : rp;
	end

	// Lane sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) st_q <= ST_MUL;
				end
				ST_MUL: st_q <= ST_RND;
				ST_RND: st_q <= ST_RC0;
				ST_RC0: st_q <= ST_RC1;
				ST_RC1: st_q <= ST_RC2;
				ST_RC2: st_q <= ST_FIN;
				ST_FIN: begin
					st_q   <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			absd_q <= absd;
			neg_q  <= diff[32];
		end
		if (st_q == ST_MUL) begin
			mag_q <= 65'(prod) + (absd_q[32] ? {1'b0, inv, 32'd0} : 65'd0);
		end
		if (st_q == ST_RND) begin
			near_neg_q <= near[33];
			nsh_q      <= nabs;
			pside_q    <= t[15];
			a_q        <= a_n;
		end
		if (st_q == ST_RC0) begin
			plo_q    <= plo;
			wgt_q[0] <= W_CENTER - aa;
			wgt_q[1] <= 32'(sq_p >> 1);
			wgt_q[2] <= 32'(sq_m >> 1);
		end
		if (st_q == ST_RC1) quo_q <= qsum[65:34];
		if (st_q == ST_RC2) rest_q <= rest[IW:0];
		if (st_q == ST_FIN) begin
			off_q[0] <= CELL_AW_MAX'(AW'(r) * STRIDE_V);
			off_q[1] <= CELL_AW_MAX'(AW'(i1) * STRIDE_V);
			off_q[2] <= CELL_AW_MAX'(AW'(i2) * STRIDE_V);
		end
	end

endmodule

// ===== design/tgdi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid: front end
// Accepts request words, classifies them, runs the three axis lanes for
// deposits and interpolations, and hands a job word to the back end.
// ----------------------------------------------------------------------------
module tgdi_front
	import tgdi_pkg::*;
#(
	parameter int GRID_X = GRID_X_DEF,
	parameter int GRID_Y = GRID_Y_DEF,
	parameter int GRID_Z = GRID_Z_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t item,
	output logic     full,
	input  logic     hold,
	input  cfg_t     cfg,
	output logic     job_push,
	output job_t     job,
	input  logic     job_full
);
	localparam int AW = $clog2(GRID_X * GRID_Y * GRID_Z);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CALC = 2'd1;
	localparam logic [1:0] F_HOLD = 2'd2;

	logic [1:0] st_q;
	job_t       job_q;
	logic       accept, need_calc;
	logic [2:0] quick_op;
	logic       dx, dy, dz;
	off_t [2:0] ox, oy, oz;
	wgt_t [2:0] wx, wy, wz;

	assign full     = (st_q != F_IDLE) || hold;
	assign accept   = push && !full;
	assign job_push = (st_q == F_HOLD) && !job_full;
	assign job      = job_q;

	// Classify the request.
	always_comb begin
		need_calc = 1'b0;
		quick_op  = JOB_NOP;
		unique case (item.req_type)
			REQ_CLEAR: quick_op = JOB_CLEAR;
			REQ_DEPOSIT: need_calc = (item.particle_type == cfg.deposit_type);
			REQ_INTERP: need_calc = 1'b1;
			REQ_READ: quick_op = JOB_READ;
			default: quick_op = JOB_NOP;
		endcase
	end

	tgdi_axis #(.SIZE(GRID_X), .STRIDE(1), .AW(AW)) u_ax (
		.clk(clk), .arst_n(arst_n), .start(accept && need_calc),
		.pos(item.pos_x), .origin(cfg.origin_x), .inv(cfg.inv_cell_size),
		.done(dx), .off(ox), .wgt(wx)
	);
	tgdi_axis #(.SIZE(GRID_Y), .STRIDE(GRID_X), .AW(AW)) u_ay (
		.clk(clk), .arst_n(arst_n), .start(accept && need_calc),
		.pos(item.pos_y), .origin(cfg.origin_y), .inv(cfg.inv_cell_size),
		.done(dy), .off(oy), .wgt(wy)
	);
	tgdi_axis #(.SIZE(GRID_Z), .STRIDE(GRID_X * GRID_Y), .AW(AW)) u_az (
		.clk(clk), .arst_n(arst_n), .start(accept && need_calc),
		.pos(item.pos_z), .origin(cfg.origin_z), .inv(cfg.inv_cell_size),
		.done(dz), .off(oz), .wgt(wz)
	);

	// Front sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (accept) st_q <= need_calc ? F_CALC : F_HOLD;
				end
				F_CALC: begin
					if (dx && dy && dz) st_q <= F_HOLD;
				end
				F_HOLD: begin
					if (!job_full) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	// Job word.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.op         <= need_calc ? ((item.req_type == REQ_DEPOSIT) ?
			                    JOB_DEPOSIT : JOB_INTERP) : quick_op;
			job_q.mass       <= item.mass;
			job_q.cell_index <= item.cell_index;
		end
		if (st_q == F_CALC && dx && dy && dz) begin
			job_q.offx <= ox;
			job_q.offy <= oy;
			job_q.offz <= oz;
			job_q.wx   <= wx;
			job_q.wy   <= wy;
			job_q.wz   <= wz;
		end
	end

endmodule

// ===== design/tgdi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid: back end
// Owns the grid memory. Sweeps it for clears, walks the 27 cells of a
// deposit or interpolation through a short pipeline, and scales cell reads.
// ----------------------------------------------------------------------------
module tgdi_back
	import tgdi_pkg::*;
#(
	parameter int GRID_X = GRID_X_DEF,
	parameter int GRID_Y = GRID_Y_DEF,
	parameter int GRID_Z = GRID_Z_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  logic      job_empty,
	output logic      job_pop,
	input  cfg_t      cfg,
	output logic      res_push,
	output out_word_t res,
	input  logic      res_full,
	output logic      clearing
);
	localparam int NCELLS = GRID_X * GRID_Y * GRID_Z;
	localparam int AW = $clog2(NCELLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
	localparam logic [1:0] TAP_LAST = 2'd2;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_CLR   = 3'd1;
	localparam logic [2:0] B_RUN   = 3'd2;
	localparam logic [2:0] B_DRAIN = 3'd3;
	localparam logic [2:0] B_RD0   = 3'd4;
	localparam logic [2:0] B_RD1   = 3'd5;
	localparam logic [2:0] B_RD2   = 3'd6;
	localparam logic [2:0] B_DONE  = 3'd7;

	logic [31:0] mem [NCELLS];

	logic [2:0]    st_q;
	logic          init_q;
	job_t          cur_q;
	logic [AW-1:0] caddr_q;
	logic [1:0]    ci_q, cj_q, ck_q;
	logic [36:0]   acc_q;
	logic [31:0]   val_q;
	logic          sat_q;
	logic [31:0]   rd_q;
	logic [63:0]   pread_q;

	logic          v_s1, v_s2, v_s3;
	logic [63:0]   wxy_s1;
	logic [31:0]   wz_s1, wc_s2, prod_s3, rd_s3;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;

	logic          last_tap, in_range, we;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_data, mul_a;
	logic [63:0]   wc_full, prod_full;
	logic [32:0]   dep_sum;
	logic [47:0]   p_read;

	assign clearing = init_q;
	assign job_pop  = (st_q == B_IDLE) && !job_empty && !res_full;
	assign res_push = (st_q == B_DONE);
	assign last_tap = (ci_q == TAP_LAST) && (cj_q == TAP_LAST) && (ck_q == TAP_LAST);
	assign in_range = (32'(cur_q.cell_index) < 32'(NCELLS));

	// Result word.
	always_comb begin
		res.value     = val_q;
		res.saturated = sat_q;
		if (cur_q.op == JOB_INTERP) begin
			res.value     = (acc_q[36:32] != '0) ? SAT_VALUE : acc_q[31:0];
			res.saturated = (acc_q[36:32] != '0);
		end
	end

	// Arithmetic for the cell pipeline and the cell read.
	always_comb begin
		wc_full   = wxy_s1[63:32] * wz_s1;
		mul_a     = (cur_q.op == JOB_DEPOSIT) ? cur_q.mass : rd_q;
		prod_full = mul_a * wc_s2;
		dep_sum   = {1'b0, rd_s3} + {1'b0, prod_s3};
		p_read    = pread_q[63:16];
	end

	// Memory port selection.
	always_comb begin
		rd_addr = (st_q == B_RD0) ? AW'(cur_q.cell_index) : addr_s1;
		we      = (st_q == B_CLR) || (v_s3 && cur_q.op == JOB_DEPOSIT);
		wr_addr = (st_q == B_CLR) ? caddr_q : addr_s3;
		wr_data = (st_q == B_CLR) ? 32'd0 : (dep_sum[32] ? SAT_VALUE : dep_sum[31:0]);
	end

	// Grid memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Back sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_CLR;
			init_q  <= 1'b1;
			caddr_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ci_q    <= '0;
			cj_q    <= '0;
			ck_q    <= '0;
		end else begin
			v_s1 <= (st_q == B_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (st_q)
				B_IDLE: begin
					if (job_pop) begin
						ci_q    <= '0;
						cj_q    <= '0;
						ck_q    <= '0;
						caddr_q <= '0;
						unique case (job.op) inside
							JOB_CLEAR: st_q <= B_CLR;
							JOB_DEPOSIT, JOB_INTERP: st_q <= B_RUN;
							JOB_READ: st_q <= B_RD0;
							default: st_q <= B_DONE;
						endcase
					end
				end
				B_CLR: begin
					caddr_q <= caddr_q + 1'b1;
					if (caddr_q == LAST_CELL) begin
						init_q <= 1'b0;
						st_q   <= init_q ? B_IDLE : B_DONE;
					end
				end
				B_RUN: begin
					if (ci_q == TAP_LAST) begin
						ci_q <= '0;
						if (cj_q == TAP_LAST) begin
							cj_q <= '0;
							ck_q <= ck_q + 1'b1;
						end else begin
							cj_q <= cj_q + 1'b1;
						end
					end else begin
						ci_q <= ci_q + 1'b1;
					end
					if (last_tap) st_q <= B_DRAIN;
				end
				B_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) st_q <= B_DONE;
				end
				B_RD0: st_q <= B_RD1;
				B_RD1: st_q <= B_RD2;
				B_RD2: st_q <= B_DONE;
				B_DONE: st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// Job capture, accumulators and the cell pipeline.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_q <= job;
			acc_q <= '0;
			val_q <= '0;
			sat_q <= 1'b0;
		end
		// Stage 1: x*y weight and cell address.
		wxy_s1  <= cur_q.wx[ci_q] * cur_q.wy[cj_q];
		wz_s1   <= cur_q.wz[ck_q];
		addr_s1 <= cur_q.offx[ci_q][AW-1:0] + cur_q.offy[cj_q][AW-1:0] +
		           cur_q.offz[ck_q][AW-1:0];
		// Stage 2: full cell weight; the cell is read from memory.
		wc_s2   <= wc_full[63:32];
		addr_s2 <= addr_s1;
		// Stage 3: weighted mass or weighted cell.
		prod_s3 <= prod_full[63:32];
		rd_s3   <= rd_q;
		addr_s3 <= addr_s2;
		// Stage 4: deposit write-back or interpolation sum.
		if (v_s3) begin
			if (cur_q.op == JOB_DEPOSIT) begin
				if (dep_sum[32]) sat_q <= 1'b1;
			end else begin
				acc_q <= acc_q + 37'(prod_s3);
			end
		end
		// Scaled cell read.
		if (st_q == B_RD1) pread_q <= rd_q * cfg.volume_scale;
		if (st_q == B_RD2) begin
			if (in_range) begin
				val_q <= (p_read[47:32] != '0) ? SAT_VALUE : p_read[31:0];
				sat_q <= (p_read[47:32] != '0);
			end
		end
	end

endmodule

// ===== design/tsc_grid_deposit_interpolate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TSC grid deposit / interpolate engine: top level
// Triangular-shaped-cloud mass assignment and interpolation over a periodic
// 3D grid, with an APB register port and queue-style request/result sides.
// ----------------------------------------------------------------------------
// Each request word gives exactly one result word, in order. The front end
// maps a deposit or interpolation position to its 3x3x3 cells and weights:
// each axis lane takes six steps (the three axes run side by side), three of
// them for the reciprocal multiplication that wraps the cell index, and the
// job word is then handed over. The back end issues one cell per cycle from
// the grid memory, which has a separate write port and registered read port,
// over all 27 cells, then drains its cell pipeline and hands off the result.
// Front and back overlap through a two-word job queue, so a stream of
// deposits or interpolations is paced by the back end.
// A cell read runs through the back end's read states; a clear walks every
// cell. After reset the block clears the grid in the same way and holds full
// high meanwhile; register writes are taken throughout.
// ----------------------------------------------------------------------------
module tsc_grid_deposit_interpolate
	import tgdi_pkg::*;
#(
	parameter int GRID_X = GRID_X_DEF,
	parameter int GRID_Y = GRID_Y_DEF,
	parameter int GRID_Z = GRID_Z_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_word_t    item,
	input  logic        pop,
	output logic        empty,
	output out_word_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int JOB_W = $bits(job_t);
	localparam int RES_W = $bits(out_word_t);

	cfg_t       cfg_q;
	logic       cfg_we, clearing;
	logic [2:0] reg_idx;

	job_t             job_in, job_out;
	logic [JOB_W-1:0] job_out_v;
	logic             job_push, job_full, job_pop, job_empty;
	out_word_t        res_in;
	logic [RES_W-1:0] res_out_v;
	logic             res_push, res_full;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.origin_z      <= '0;
			cfg_q.inv_cell_size <= ONE_Q16;
			cfg_q.volume_scale  <= ONE_Q16;
			cfg_q.deposit_type  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_ORIGIN_X:     cfg_q.origin_x      <= pwdata;
				REG_ORIGIN_Y:     cfg_q.origin_y      <= pwdata;
				REG_ORIGIN_Z:     cfg_q.origin_z      <= pwdata;
				REG_INV_CELL:     cfg_q.inv_cell_size <= pwdata;
				REG_VOLUME_SCALE: cfg_q.volume_scale  <= pwdata;
				REG_DEPOSIT_TYPE: cfg_q.deposit_type  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_ORIGIN_X:     prdata = cfg_q.origin_x;
			REG_ORIGIN_Y:     prdata = cfg_q.origin_y;
			REG_ORIGIN_Z:     prdata = cfg_q.origin_z;
			REG_INV_CELL:     prdata = cfg_q.inv_cell_size;
			REG_VOLUME_SCALE: prdata = cfg_q.volume_scale;
			REG_DEPOSIT_TYPE: prdata = {24'd0, cfg_q.deposit_type};
			default:          prdata = 32'd0;
		endcase
	end

	tgdi_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.hold(clearing), .cfg(cfg_q), .job_push(job_push), .job(job_in),
		.job_full(job_full)
	);

	tgdi_fifo #(.W(JOB_W), .DEPTH(2)) u_job_q (
		.clk(clk), .arst_n(arst_n), .wr(job_push), .wdata(job_in), .full(job_full),
		.rd(job_pop), .rdata(job_out_v), .empty(job_empty)
	);
	assign job_out = job_out_v;

	tgdi_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
		.clk(clk), .arst_n(arst_n), .job(job_out), .job_empty(job_empty),
		.job_pop(job_pop), .cfg(cfg_q), .res_push(res_push), .res(res_in),
		.res_full(res_full), .clearing(clearing)
	);

	tgdi_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .wdata(res_in), .full(res_full),
		.rd(pop), .rdata(res_out_v), .empty(empty)
	);
	assign result = res_out_v;

endmodule
